@@ hw/rtl/fuzzy_membership_grade_defines.svh @@
// Assertion macros for the fuzzy membership grade block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FUZZY_MEMBERSHIP_GRADE_DEFINES_SVH
`define FUZZY_MEMBERSHIP_GRADE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMG_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("fmg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FMG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("fmg: next-cycle check failed");

`endif

@@ hw/rtl/fmg_pkg.sv @@
// Shared types, constants and divider step functions of the fuzzy membership grade block.
// No dependencies; every other file of the block but the defines header imports it.
package fmg_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int FRACTION_BITS   = 15;
  localparam int GRADE_WIDTH     = 16;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int REG_COUNT       = 5;
  localparam int CFG_ADDR_WIDTH  = 5;
  localparam int REG_INDEX_WIDTH = CFG_ADDR_WIDTH - 2;

  // Restoring division: a few quotient bits per pipeline stage.
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = (FRACTION_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  typedef logic [SAMPLE_WIDTH-1:0]  value_t;
  typedef logic [FRACTION_BITS-1:0] quo_t;
  typedef logic [GRADE_WIDTH-1:0]   grade_t;

  typedef enum logic [1:0] {
    MODE_RISE = 2'd0,
    MODE_FALL = 2'd1,
    MODE_TRI  = 2'd2,
    MODE_TRAP = 2'd3
  } fmg_mode_t;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_MODE    = 3'd0,
    REG_POINT_A = 3'd1,
    REG_POINT_B = 3'd2,
    REG_POINT_C = 3'd3,
    REG_POINT_D = 3'd4
  } fmg_reg_t;

  // How the grade of an item is finally formed.
  typedef enum logic [1:0] {
    CODE_ZERO = 2'd0,
    CODE_FULL = 2'd1,
    CODE_DIV  = 2'd2
  } fmg_code_t;

  typedef struct packed {
    fmg_mode_t mode;
    value_t    point_a;
    value_t    point_b;
    value_t    point_c;
    value_t    point_d;
  } fmg_cfg_t;

  typedef struct packed {
    fmg_code_t code;
    logic      bad;
    value_t    rem;
    value_t    den;
    quo_t      quo;
  } fmg_pkt_t;

  // One restoring step: the shifted-in dividend bits are all zero.
  function automatic fmg_pkt_t div_step(fmg_pkt_t p);
    fmg_pkt_t                r;
    logic [SAMPLE_WIDTH:0]   t;
    logic [SAMPLE_WIDTH:0]   diff;
    logic                    take;
    r    = p;
    t    = {p.rem, 1'b0};
    diff = t - {1'b0, p.den};
    take = (t >= {1'b0, p.den});
    r.rem = take ? diff[SAMPLE_WIDTH-1:0] : t[SAMPLE_WIDTH-1:0];
    r.quo = {p.quo[FRACTION_BITS-2:0], take};
    return r;
  endfunction

  // The steps of one pipeline stage; the last stage may have fewer.
  function automatic fmg_pkt_t div_stage(fmg_pkt_t p, int stage);
    fmg_pkt_t r;
    r = p;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      if (stage * STEPS_PER_STAGE + k < FRACTION_BITS) begin
        r = div_step(r);
      end
    end
    return r;
  endfunction

  function automatic grade_t make_grade(fmg_pkt_t p);
    logic [FRACTION_BITS:0] g;
    logic [31:0]            w;
    case (p.code)
      CODE_FULL: g = {1'b1, {FRACTION_BITS{1'b0}}};
      CODE_DIV:  g = {1'b0, p.quo};
      default:   g = '0;
    endcase
    w = 32'(g);
    return w[GRADE_WIDTH-1:0];
  endfunction

endpackage

@@ hw/rtl/fmg_in_if.sv @@
// Request channel carrying one crisp sample.
// Depends on fmg_pkg for the sample width.
interface fmg_in_if;
  import fmg_pkg::*;

  logic   valid;
  logic   ready;
  value_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hw/rtl/fmg_out_if.sv @@
// Result channel carrying one membership grade and the order flag.
// Depends on fmg_pkg for the grade width.
interface fmg_out_if;
  import fmg_pkg::*;

  logic   valid;
  logic   ready;
  grade_t grade;
  logic   order_error;

  modport source (output valid, output grade, output order_error, input ready);
  modport sink   (input valid, input grade, input order_error, output ready);
endinterface

@@ hw/rtl/fmg_classify.sv @@
// First pipeline stage: checks breakpoint order, picks the segment and sets up the division.
// Depends on fmg_pkg.
module fmg_classify (
  input  logic              clk,
  input  logic              rst_n,
  input  fmg_pkg::fmg_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  fmg_pkg::value_t   in_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output fmg_pkg::fmg_pkt_t out_pkt
);
  import fmg_pkg::*;

  logic     valid_r;
  fmg_pkt_t pkt_r;
  fmg_pkt_t pkt_nxt;
  value_t   v, a, b, c, d;

  assign v = in_sample;
  assign a = cfg.point_a;
  assign b = cfg.point_b;
  assign c = cfg.point_c;
  assign d = cfg.point_d;

  always_comb begin
    pkt_nxt      = '0;
    pkt_nxt.code = CODE_ZERO;
    case (cfg.mode)
      MODE_RISE: begin
        pkt_nxt.bad = (a > b);
        if (v <= a) begin
          pkt_nxt.code = CODE_ZERO;
        end else if (v >= b) begin
          pkt_nxt.code = CODE_FULL;
        end else begin
          pkt_nxt.code = CODE_DIV;
          pkt_nxt.rem  = v - a;
          pkt_nxt.den  = b - a;
        end
      end
      MODE_FALL: begin
        pkt_nxt.bad = (a > b);
        if (v <= a) begin
          pkt_nxt.code = CODE_FULL;
        end else if (v >= b) begin
          pkt_nxt.code = CODE_ZERO;
        end else begin
          pkt_nxt.code = CODE_DIV;
          pkt_nxt.rem  = b - v;
          pkt_nxt.den  = b - a;
        end
      end
      MODE_TRI: begin
        pkt_nxt.bad = (a > b) || (b > c);
        if (v <= a || v >= c) begin
          pkt_nxt.code = CODE_ZERO;
        end else if (v < b) begin
          pkt_nxt.code = CODE_DIV;
          pkt_nxt.rem  = v - a;
          pkt_nxt.den  = b - a;
        end else if (v == b) begin
          // The peak itself: the falling ramp starts at full grade.
          pkt_nxt.code = CODE_FULL;
        end else begin
          pkt_nxt.code = CODE_DIV;
          pkt_nxt.rem  = c - v;
          pkt_nxt.den  = c - b;
        end
      end
      MODE_TRAP: begin
        pkt_nxt.bad = (a > b) || (b > c) || (c > d);
        if (v <= a || v >= d) begin
          pkt_nxt.code = CODE_ZERO;
        end else if (v >= b && v <= c) begin
          pkt_nxt.code = CODE_FULL;
        end else if (v < b) begin
          pkt_nxt.code = CODE_DIV;
          pkt_nxt.rem  = v - a;
          pkt_nxt.den  = b - a;
        end else begin
          pkt_nxt.code = CODE_DIV;
          pkt_nxt.rem  = d - v;
          pkt_nxt.den  = d - c;
        end
      end
      default: pkt_nxt.code = CODE_ZERO;
    endcase
    if (pkt_nxt.bad) begin
      pkt_nxt.code = CODE_ZERO;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pkt   = pkt_r;
endmodule

@@ hw/rtl/fmg_divider.sv @@
// Pipelined restoring divider that forms the ramp quotient a few bits per stage.
// Depends on fmg_pkg for the packet type and the stage function.
module fmg_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fmg_pkg::fmg_pkt_t in_pkt,
  output logic              out_valid,
  input  logic              out_ready,
  output fmg_pkg::fmg_pkt_t out_pkt
);
  import fmg_pkg::*;

  logic                valid_r [DIV_STAGES];
  fmg_pkt_t            pkt_r   [DIV_STAGES];
  fmg_pkt_t            pkt_nxt [DIV_STAGES];
  logic [DIV_STAGES:0] rdy;

  assign rdy[DIV_STAGES] = out_ready;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic     src_valid;
    fmg_pkt_t src_pkt;

    if (s == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_pkt   = in_pkt;
    end else begin : g_rest
      assign src_valid = valid_r[s-1];
      assign src_pkt   = pkt_r[s-1];
    end

    // A stage takes a new request when it is empty or its content moves on.
    assign rdy[s]     = !valid_r[s] || rdy[s+1];
    assign pkt_nxt[s] = div_stage(src_pkt, s);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_r[s] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && src_valid) begin
        pkt_r[s] <= pkt_nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_pkt   = pkt_r[DIV_STAGES-1];
endmodule

@@ hw/rtl/fuzzy_membership_grade.sv @@
// Top level of the fuzzy membership grade block: register port, pipeline and result register.
// Depends on fmg_pkg, fmg_in_if, fmg_out_if, fmg_classify, fmg_divider and the defines header.
//
//   channel  direction  payload               handshake
//   in_ch    sink       sample                valid / ready
//   out_ch   source     grade, order_error    valid / ready
//   cfg_*    slave      32-bit registers      APB write in setup + access cycles
//
// One request enters per cycle unless the output stalls the pipeline; each request
// passes through one stage to classify, one stage per three quotient bits of the
// restoring divider (DIV_STAGES in all), and the result register.
// Reset clears the valid bits of every stage and loads the register reset values.
// Each stage holds while the one after it is full and stalled, so bubbles close up.
`include "fuzzy_membership_grade_defines.svh"

module fuzzy_membership_grade (
  input  logic                                 clk,
  input  logic                                 rst_n,
  fmg_in_if.sink                               in_ch,
  fmg_out_if.source                            out_ch,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [fmg_pkg::CFG_ADDR_WIDTH-1:0]   cfg_paddr,
  input  logic [fmg_pkg::CFG_DATA_WIDTH-1:0]   cfg_pwdata,
  output logic [fmg_pkg::CFG_DATA_WIDTH-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);
  import fmg_pkg::*;

  fmg_cfg_t cfg_r;
  fmg_cfg_t cfg_nxt;
  fmg_reg_t reg_idx;
  logic     cfg_wr;

  logic     cls_valid, cls_ready;
  fmg_pkt_t cls_pkt;
  logic     div_valid, div_ready;
  fmg_pkt_t div_pkt;

  logic     out_valid_r;
  grade_t   grade_r;
  logic     err_r;

  // Register port
  assign cfg_pready = 1'b1;
  assign reg_idx    = fmg_reg_t'(cfg_paddr[CFG_ADDR_WIDTH-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:    cfg_nxt.mode    = fmg_mode_t'(cfg_pwdata[1:0]);
        REG_POINT_A: cfg_nxt.point_a = cfg_pwdata[SAMPLE_WIDTH-1:0];
        REG_POINT_B: cfg_nxt.point_b = cfg_pwdata[SAMPLE_WIDTH-1:0];
        REG_POINT_C: cfg_nxt.point_c = cfg_pwdata[SAMPLE_WIDTH-1:0];
        REG_POINT_D: cfg_nxt.point_d = cfg_pwdata[SAMPLE_WIDTH-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= MODE_TRAP;
      cfg_r.point_a <= '0;
      cfg_r.point_b <= '0;
      cfg_r.point_c <= '0;
      cfg_r.point_d <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:    cfg_prdata = CFG_DATA_WIDTH'(cfg_r.mode);
      REG_POINT_A: cfg_prdata = CFG_DATA_WIDTH'(cfg_r.point_a);
      REG_POINT_B: cfg_prdata = CFG_DATA_WIDTH'(cfg_r.point_b);
      REG_POINT_C: cfg_prdata = CFG_DATA_WIDTH'(cfg_r.point_c);
      REG_POINT_D: cfg_prdata = CFG_DATA_WIDTH'(cfg_r.point_d);
      default:     cfg_prdata = '0;
    endcase
  end

  // Pipeline
  fmg_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_sample (in_ch.sample),
    .out_valid (cls_valid),
    .out_ready (cls_ready),
    .out_pkt   (cls_pkt)
  );

  fmg_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_pkt    (cls_pkt),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_pkt   (div_pkt)
  );

  // Result register
  assign div_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) begin
      grade_r <= make_grade(div_pkt);
      err_r   <= div_pkt.bad;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.grade       = grade_r;
  assign out_ch.order_error = err_r;

  // Checks
  `FMG_ASSERT_NOW(a_error_zero_grade, clk, rst_n,
                  out_ch.valid && out_ch.order_error, out_ch.grade == '0)
  `FMG_ASSERT_NOW(a_div_operands, clk, rst_n,
                  cls_valid && (cls_pkt.code == CODE_DIV),
                  (cls_pkt.den != '0) && (cls_pkt.rem < cls_pkt.den))
  `FMG_ASSERT_NEXT(a_div_hold, clk, rst_n,
                   div_valid && !div_ready, div_valid && $stable(div_pkt))
endmodule
